FILE: hw/rtl/drrip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package drrip_pkg;

  localparam int NUM_SETS     = 2048;
  localparam int NUM_WAYS     = 16;
  localparam int LEADER_GROUP = 32;

  localparam int SET_W     = $clog2(NUM_SETS);
  localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int ROW_W     = 2 * NUM_WAYS;
  localparam int SET_EXT_W = 18;
  localparam int WAY_EXT_W = 7;
  localparam int SEL_W     = 10;
  localparam int LINE_W    = 8;
  localparam int LINE_SHIFT = 6;

  typedef logic [1:0] rrpv_t;

  localparam rrpv_t RRPV_NEAR = 2'd0;
  localparam rrpv_t RRPV_LONG = 2'd2;
  localparam rrpv_t RRPV_MAX  = 2'd3;

  localparam logic [SEL_W-1:0] SEL_MAX  = 10'd1023;
  localparam logic [SEL_W-1:0] SEL_MID  = 10'd512;
  localparam logic [SEL_W-1:0] SEL_ZERO = 10'd0;

  localparam logic [ROW_W-1:0] ROW_RESET = {NUM_WAYS{RRPV_MAX}};

  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic              op;
    logic              in_range;
    logic              srrip_leader;
    logic              brrip_leader;
    logic [SET_W-1:0]  set;
    logic [3:0]        way;
    logic [63:0]       addr;
    logic              hit;
    logic [4:0]        draw;
  } req_t;

  typedef struct packed {
    logic [LINE_W-1:0] line_low;
    logic              addr_nz;
    logic [LINE_W-1:0] stride;
    logic [1:0]        score;
  } strm_ent_t;

  localparam strm_ent_t STRM_RESET = '{line_low: '0, addr_nz: 1'b0, stride: '0, score: 2'd0};

endpackage
`default_nettype wire

FILE: hw/rtl/drrip_set_logic.sv
`timescale 1ns / 1ps
`default_nettype none
module drrip_set_logic (
  input  wire drrip_pkg::req_t             req,
  input  wire logic [drrip_pkg::ROW_W-1:0] row_i,
  input  wire drrip_pkg::strm_ent_t        strm_i,
  input  wire logic [drrip_pkg::SEL_W-1:0] sel_i,
  output logic [drrip_pkg::ROW_W-1:0]      row_o,
  output drrip_pkg::strm_ent_t             strm_o,
  output logic [3:0]                       victim_o,
  output logic                             streaming_o,
  output logic [drrip_pkg::SEL_W-1:0]      sel_o
);
  import drrip_pkg::*;

  rrpv_t             vals [NUM_WAYS];
  rrpv_t             top;
  rrpv_t             add;
  rrpv_t             ins;
  logic [ROW_W-1:0]  aged_row;
  logic [ROW_W-1:0]  upd_row;
  logic [WAY_W-1:0]  victim_w;
  logic              any_hi;
  logic              any_lo;
  logic [LINE_W-1:0] line_now;
  logic [LINE_W-1:0] stride;
  logic              match;
  strm_ent_t         strm_upd;
  logic              streaming_upd;
  logic              srrip_pick;
  logic              way_ok;
  logic [SEL_W-1:0]  sel_upd;

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      vals[w] = row_i[2*w +: 2];
    end
  end

  // largest value in the set, from the bit planes
  always_comb begin
    any_hi = 1'b0;
    any_lo = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      any_hi = any_hi | vals[w][1];
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      any_lo = any_lo | ((vals[w][1] == any_hi) & vals[w][0]);
    end
    top = {any_hi, any_lo};
    add = RRPV_MAX - top;
  end

  // aging brings the largest to three, so the victim is the first way at the maximum
  always_comb begin
    victim_w = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (vals[w] == top) begin
        victim_w = WAY_W'(w);
      end
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged_row[2*w +: 2] = vals[w] + add;
    end
  end

  // stream detector
  always_comb begin
    line_now = req.addr[LINE_SHIFT +: LINE_W];
    stride   = strm_i.addr_nz ? (line_now - strm_i.line_low) : '0;
    match    = (stride != '0) && (stride == strm_i.stride);
    strm_upd.line_low = line_now;
    strm_upd.addr_nz  = (req.addr != 64'd0);
    if (match) begin
      strm_upd.stride = strm_i.stride;
      strm_upd.score  = (strm_i.score == 2'd3) ? 2'd3 : strm_i.score + 2'd1;
    end else begin
      strm_upd.stride = stride;
      strm_upd.score  = 2'd0;
    end
    streaming_upd = (strm_upd.score >= 2'd2);
  end

  // insertion value and row write
  always_comb begin
    if (req.srrip_leader) begin
      srrip_pick = 1'b1;
    end else if (req.brrip_leader) begin
      srrip_pick = 1'b0;
    end else begin
      srrip_pick = (sel_i >= SEL_MID);
    end
    if (req.hit) begin
      ins = RRPV_NEAR;
    end else if (streaming_upd) begin
      ins = RRPV_MAX;
    end else if (srrip_pick) begin
      ins = RRPV_LONG;
    end else begin
      ins = (req.draw == 5'd0) ? RRPV_LONG : RRPV_MAX;
    end
    way_ok = (WAY_EXT_W'(req.way) < WAY_EXT_W'(NUM_WAYS));
    for (int w = 0; w < NUM_WAYS; w++) begin
      upd_row[2*w +: 2] = (way_ok && (WAY_EXT_W'(req.way) == WAY_EXT_W'(w))) ? ins : vals[w];
    end
  end

  // dueling selector, saturating
  always_comb begin
    sel_upd = sel_i;
    if (req.hit) begin
      if (req.srrip_leader && (sel_i != SEL_MAX)) begin
        sel_upd = sel_i + SEL_W'(1);
      end else if (req.brrip_leader && (sel_i != SEL_ZERO)) begin
        sel_upd = sel_i - SEL_W'(1);
      end
    end
  end

  always_comb begin
    row_o       = row_i;
    strm_o      = strm_i;
    victim_o    = 4'd0;
    streaming_o = 1'b0;
    sel_o       = sel_i;
    if (req.in_range) begin
      if (req.op == OP_UPDATE) begin
        row_o       = upd_row;
        strm_o      = strm_upd;
        streaming_o = streaming_upd;
        sel_o       = sel_upd;
      end else begin
        row_o       = aged_row;
        victim_o    = 4'(victim_w);
        streaming_o = (strm_i.score >= 2'd2);
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/drrip_replacement_with_stream_detect.sv
`timescale 1ns / 1ps
`default_nettype none
// latency: a request is read from the set memories in its accept cycle, and the result
//   is registered in the read-modify-write state once the output register is free
// pacing: a new request is taken only after the read-modify-write of the previous set row
// reset: synchronous active-low; a clearing pass over all 2048 sets (one set per cycle)
//   initializes both memories, and no request is taken until it finishes
module drrip_replacement_with_stream_detect (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_operation,
  input  wire logic [10:0] in_set_index,
  input  wire logic [3:0]  in_way_index,
  input  wire logic [63:0] in_address,
  input  wire logic        in_was_hit,
  input  wire logic [4:0]  in_random_draw,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_victim_way,
  output logic             out_set_streaming,
  output logic [9:0]       out_selector_value
);
  import drrip_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RMW   = 2'd2;

  logic [1:0]       state_r;
  logic [1:0]       state_nxt;
  logic [SET_W-1:0] clr_cnt_r;
  req_t             req_r;
  logic [SEL_W-1:0] sel_r;
  logic             out_valid_r;
  logic [3:0]       out_victim_r;
  logic             out_strm_r;
  logic [SEL_W-1:0] out_sel_r;

  logic [ROW_W-1:0] rrpv_mem [NUM_SETS];
  strm_ent_t        strm_mem [NUM_SETS];
  logic [ROW_W-1:0] rrpv_rd_r;
  strm_ent_t        strm_rd_r;

  logic [SET_EXT_W-1:0] set_ext;
  logic                 in_acc;
  logic                 out_free;
  logic                 rmw_go;
  logic                 mem_we;
  logic [SET_W-1:0]     mem_wa;
  logic [ROW_W-1:0]     rrpv_wd;
  strm_ent_t            strm_wd;

  logic [ROW_W-1:0] row_new;
  strm_ent_t        strm_new;
  logic [3:0]       victim;
  logic             streaming;
  logic [SEL_W-1:0] sel_nxt;

  assign set_ext  = SET_EXT_W'(in_set_index);
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign rmw_go   = (state_r == ST_RMW) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == SET_W'(NUM_SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_RMW;
        end
      end
      ST_RMW: begin
        if (rmw_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      sel_r     <= SEL_MID;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + SET_W'(1);
      end
      if (rmw_go) begin
        sel_r <= sel_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r.op           <= in_operation;
      req_r.in_range     <= (set_ext < SET_EXT_W'(NUM_SETS));
      req_r.srrip_leader <= (set_ext < SET_EXT_W'(LEADER_GROUP));
      req_r.brrip_leader <= (set_ext >= SET_EXT_W'(LEADER_GROUP)) &&
                            (set_ext < SET_EXT_W'(2 * LEADER_GROUP));
      req_r.set          <= set_ext[SET_W-1:0];
      req_r.way          <= in_way_index;
      req_r.addr         <= in_address;
      req_r.hit          <= in_was_hit;
      req_r.draw         <= in_random_draw;
    end
  end

  // a request is only accepted after the previous write-back, so reads never see stale rows
  assign mem_we  = (state_r == ST_CLEAR) || (rmw_go && req_r.in_range);
  assign mem_wa  = (state_r == ST_CLEAR) ? clr_cnt_r : req_r.set;
  assign rrpv_wd = (state_r == ST_CLEAR) ? ROW_RESET : row_new;
  assign strm_wd = (state_r == ST_CLEAR) ? STRM_RESET : strm_new;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      rrpv_mem[mem_wa] <= rrpv_wd;
    end
    if (in_acc) begin
      rrpv_rd_r <= rrpv_mem[set_ext[SET_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      strm_mem[mem_wa] <= strm_wd;
    end
    if (in_acc) begin
      strm_rd_r <= strm_mem[set_ext[SET_W-1:0]];
    end
  end

  drrip_set_logic u_set_logic (
    .req         (req_r),
    .row_i       (rrpv_rd_r),
    .strm_i      (strm_rd_r),
    .sel_i       (sel_r),
    .row_o       (row_new),
    .strm_o      (strm_new),
    .victim_o    (victim),
    .streaming_o (streaming),
    .sel_o       (sel_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rmw_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rmw_go) begin
      out_victim_r <= victim;
      out_strm_r   <= streaming;
      out_sel_r    <= sel_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_victim_way     = out_victim_r;
  assign out_set_streaming  = out_strm_r;
  assign out_selector_value = out_sel_r;

endmodule
`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import drrip_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic              op;
    logic [SET_W-1:0]  set;
    logic [3:0]        way;
    logic [63:0]       addr;
    logic              hit;
    logic [4:0]        draw;
  } access_t;

  typedef struct packed {
    logic [3:0]       victim;
    logic             streaming;
    logic [SEL_W-1:0] selector;
  } result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_operation;
  logic [10:0] in_set_index;
  logic [3:0]  in_way_index;
  logic [63:0] in_address;
  logic        in_was_hit;
  logic [4:0]  in_random_draw;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_victim_way;
  logic        out_set_streaming;
  logic [9:0]  out_selector_value;

  // replacement state mirror
  rrpv_t            rrpv_mem [NUM_SETS][NUM_WAYS];
  logic [7:0]       last_line [NUM_SETS];
  logic             last_addr_nz [NUM_SETS];
  logic [7:0]       seen_stride [NUM_SETS];
  logic [1:0]       stride_score [NUM_SETS];
  logic [SEL_W-1:0] sel_ctr;

  result_t result_q[$];
  int      errors;
  int      n_sent;
  int      cycles;
  bit      tx_idle_en;
  bit      rx_idle_en;
  bit      hold_off;

  drrip_replacement_with_stream_detect uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_set_index       (in_set_index),
    .in_way_index       (in_way_index),
    .in_address         (in_address),
    .in_was_hit         (in_was_hit),
    .in_random_draw     (in_random_draw),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_victim_way     (out_victim_way),
    .out_set_streaming  (out_set_streaming),
    .out_selector_value (out_selector_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // receiver side: random stall bursts, or one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
        out_stall <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 99) < 15) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result: victim %0d streaming %0b selector %0d", $time,
                 out_victim_way, out_set_streaming, out_selector_value);
        errors++;
      end else begin
        exp_res = result_q.pop_front();
        if (out_victim_way !== exp_res.victim || out_set_streaming !== exp_res.streaming ||
            out_selector_value !== exp_res.selector) begin
          $display("%0t: mismatch: expected %0d/%0b/%0d, got %0d/%0b/%0d",
                   $time, exp_res.victim, exp_res.streaming, exp_res.selector,
                   out_victim_way, out_set_streaming, out_selector_value);
          errors++;
        end
      end
    end
  end

  function automatic result_t apply_access(input access_t a);
    result_t    res;
    rrpv_t      top;
    rrpv_t      add;
    rrpv_t      v;
    logic [7:0] line_now;
    logic [7:0] stride;
    logic       srrip_ldr;
    logic       brrip_ldr;
    logic       srrip_pick;
    int         s;
    int         w;
    res = '0;
    s = a.set;
    if (s < NUM_SETS) begin
      if (a.op == OP_VICTIM) begin
        top = RRPV_NEAR;
        for (w = 0; w < NUM_WAYS; w++)
          if (rrpv_mem[s][w] > top) top = rrpv_mem[s][w];
        // age the whole set so the oldest line reaches distant
        if (top != RRPV_MAX) begin
          add = RRPV_MAX - top;
          for (w = 0; w < NUM_WAYS; w++) rrpv_mem[s][w] = rrpv_mem[s][w] + add;
        end
        for (w = NUM_WAYS - 1; w >= 0; w--)
          if (rrpv_mem[s][w] == RRPV_MAX) res.victim = 4'(w);
      end else begin
        line_now = a.addr[LINE_SHIFT +: 8];
        stride = last_addr_nz[s] ? line_now - last_line[s] : 8'd0;
        last_line[s] = line_now;
        last_addr_nz[s] = (a.addr != 64'd0);
        if (stride != 8'd0 && stride == seen_stride[s]) begin
          if (stride_score[s] != 2'd3) stride_score[s]++;
        end else begin
          stride_score[s] = 2'd0;
          seen_stride[s] = stride;
        end
        srrip_ldr = s < LEADER_GROUP;
        brrip_ldr = !srrip_ldr && s < 2 * LEADER_GROUP;
        if (srrip_ldr) srrip_pick = 1'b1;
        else if (brrip_ldr) srrip_pick = 1'b0;
        else srrip_pick = sel_ctr >= SEL_MID;
        if (a.way < NUM_WAYS) begin
          if (a.hit) v = RRPV_NEAR;
          else if (stride_score[s] >= 2'd2) v = RRPV_MAX;
          else if (srrip_pick) v = RRPV_LONG;
          else v = (a.draw == 5'd0) ? RRPV_LONG : RRPV_MAX;
          rrpv_mem[s][a.way] = v;
        end
        if (a.hit) begin
          if (srrip_ldr && sel_ctr != SEL_MAX) sel_ctr++;
          else if (brrip_ldr && sel_ctr != SEL_ZERO) sel_ctr--;
        end
      end
      res.streaming = stride_score[s] >= 2'd2;
    end
    res.selector = sel_ctr;
    return res;
  endfunction

  function automatic access_t upd(input logic [SET_W-1:0] s, input logic [3:0] w,
                                  input logic [63:0] addr, input logic hit,
                                  input logic [4:0] draw);
    access_t a;
    a.op = OP_UPDATE;
    a.set = s;
    a.way = w;
    a.addr = addr;
    a.hit = hit;
    a.draw = draw;
    return a;
  endfunction

  function automatic access_t vic(input logic [SET_W-1:0] s);
    access_t a;
    a = '0;
    a.op = OP_VICTIM;
    a.set = s;
    a.way = 4'($urandom);
    a.addr = {$urandom, $urandom};
    a.hit = 1'($urandom);
    a.draw = 5'($urandom);
    return a;
  endfunction

  function automatic logic [4:0] rand_draw();
    return ($urandom_range(0, 9) < 4) ? 5'd0 : 5'($urandom);
  endfunction

  function automatic logic [63:0] rand_addr();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 2) return 64'd0;
    if (pick == 2) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [SET_W-1:0] pick_set();
    case ($urandom_range(0, 3))
      0: return SET_W'($urandom_range(0, LEADER_GROUP - 1));
      1: return SET_W'($urandom_range(LEADER_GROUP, 2 * LEADER_GROUP - 1));
      2: return SET_W'($urandom_range(64, 71));
      default: return SET_W'($urandom);
    endcase
  endfunction

  function automatic access_t noise_access();
    access_t a;
    a = upd(SET_W'($urandom), 4'($urandom), rand_addr(), 1'($urandom), rand_draw());
    a.op = 1'($urandom);
    return a;
  endfunction

  task automatic send_access(input access_t a);
    if (tx_idle_en && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= a.op;
    in_set_index   <= a.set;
    in_way_index   <= a.way;
    in_address     <= a.addr;
    in_was_hit     <= a.hit;
    in_random_draw <= a.draw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    result_q.push_back(apply_access(a));
    n_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (result_q.size() != 0);
  endtask

  // run of updates with a fixed line stride, broken now and then, then a victim
  task automatic send_stream(input logic [SET_W-1:0] s);
    logic [57:0] line_cur;
    logic [7:0]  step;
    int          n;
    int          i;
    line_cur = 58'({$urandom, $urandom});
    step = 8'($urandom_range(1, 255));
    n = $urandom_range(3, 7);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) line_cur = line_cur + 58'($urandom_range(1, 255));
      else line_cur = line_cur + {{50{step[7]}}, step};
      send_access(upd(s, 4'($urandom), {line_cur, 6'($urandom)}, $urandom_range(0, 3) == 0,
                      rand_draw()));
    end
    send_access(vic(s));
  endtask

  // touch every way of a set so that victim search may have to age it
  task automatic send_fill(input logic [SET_W-1:0] s);
    int w;
    for (w = 0; w < NUM_WAYS; w++)
      send_access(upd(s, 4'(w), rand_addr(), 1'($urandom), rand_draw()));
    repeat ($urandom_range(1, 3)) send_access(vic(s));
  endtask

  task automatic run_mix(input int count);
    int start;
    start = n_sent;
    while (n_sent - start < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: send_stream(pick_set());
        5, 6: send_fill(pick_set());
        default: send_access(noise_access());
      endcase
    end
  endtask

  task automatic test_fresh_victim();
    send_access(vic(11'd100));
    send_access(vic(11'd2047));
    send_access(vic(11'd0));
  endtask

  task automatic test_first_access();
    // a zero previous address gives a zero stride
    send_access(upd(11'd70, 4'd1, 64'd0, 1'b0, 5'd7));
    send_access(upd(11'd70, 4'd2, 64'h40, 1'b0, 5'd7));
    send_access(upd(11'd70, 4'd3, 64'h80, 1'b0, 5'd0));
  endtask

  task automatic test_stream_score();
    int i;
    for (i = 0; i < 6; i++)
      send_access(upd(11'd71, 4'(i), 64'h1000 + 64'(i) * 64'h40, 1'b0, 5'd9));
    // negative stride in the same set
    for (i = 0; i < 4; i++)
      send_access(upd(11'd71, 4'(8 + i), 64'h8000 - 64'(i) * 64'h80, 1'b0, 5'd0));
    send_access(vic(11'd71));
  endtask

  task automatic test_leader_hits();
    send_access(upd(11'd3, 4'd4, 64'h2000, 1'b1, 5'd1));
    send_access(upd(11'd40, 4'd5, 64'h3000, 1'b1, 5'd2));
    send_access(upd(11'd40, 4'd6, 64'h3040, 1'b0, 5'd0));
    send_access(upd(11'd41, 4'd6, 64'h3080, 1'b0, 5'd31));
    send_access(vic(11'd41));
  endtask

  task automatic test_field_extremes();
    send_access(upd(11'd2047, 4'd15, '1, 1'b0, 5'd31));
    send_access(upd(11'd2047, 4'd0, 64'd0, 1'b1, 5'd0));
    send_access(vic(11'd2047));
  endtask

  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    hold_off = 1'b1;
    repeat (24) send_access(noise_access());
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_mix();
    run_mix(100);
  endtask

  task automatic test_selector_sweep();
    int extra;
    extra = 0;
    while (extra < 10) begin
      if (sel_ctr == SEL_MAX) extra++;
      if ($urandom_range(0, 19) != 0)
        send_access(upd(SET_W'($urandom_range(0, LEADER_GROUP - 1)), 4'($urandom), rand_addr(),
                        1'b1, rand_draw()));
      else
        send_access(noise_access());
    end
    extra = 0;
    while (extra < 10) begin
      if (sel_ctr == SEL_ZERO) extra++;
      if ($urandom_range(0, 19) != 0)
        send_access(upd(SET_W'($urandom_range(LEADER_GROUP, 2 * LEADER_GROUP - 1)),
                        4'($urandom), rand_addr(), 1'b1, rand_draw()));
      else
        send_access(noise_access());
    end
  endtask

  task automatic test_full_rate();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_mix(80);
  endtask

  initial begin
    int s;
    int w;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = OP_VICTIM;
    in_set_index   = '0;
    in_way_index   = '0;
    in_address     = '0;
    in_was_hit     = 1'b0;
    in_random_draw = '0;
    errors         = 0;
    n_sent         = 0;
    tx_idle_en     = 1'b1;
    rx_idle_en     = 1'b1;
    hold_off       = 1'b0;
    sel_ctr        = SEL_MID;
    for (s = 0; s < NUM_SETS; s++) begin
      for (w = 0; w < NUM_WAYS; w++) rrpv_mem[s][w] = RRPV_MAX;
      last_line[s]    = '0;
      last_addr_nz[s] = 1'b0;
      seen_stride[s]  = '0;
      stride_score[s] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_fresh_victim();
    test_first_access();
    test_stream_score();
    test_leader_hits();
    test_field_extremes();
    wait_for_results();
    test_backpressure();
    wait_for_results();
    test_random_mix();
    wait_for_results();
    test_selector_sweep();
    wait_for_results();
    test_full_rate();
    wait_for_results();

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
